// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the label propagation block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

// Check that a trigger implies a condition in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed: same-cycle implication");

// Check that a trigger implies a condition in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: src/lpvu_pkg.sv
// ----------------------------------------------------------------------------
// lpvu_pkg
// Types and defaults shared by the vertex update controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpvu_pkg;

    localparam int unsigned MAX_DISTINCT_DEF = 64;
    localparam int unsigned LABEL_BITS_DEF   = 32;
    localparam int unsigned COUNT_BITS_DEF   = 16;

    localparam int unsigned PORT_LABEL_BITS  = 32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic idx_inc;
        logic insert;
        logic bump;
        logic set_ovf;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_none;
        logic in_last;
        logic last;
        logic idx_at_end;
        logic hit;
        logic full;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// File: src/label_propagation_vertex_update.sv
// ----------------------------------------------------------------------------
// label_propagation_vertex_update
// Counts a vertex's neighbor labels and returns the most frequent one.
// ----------------------------------------------------------------------------
// One neighbor word is taken at a time. Each word scans the label memory
// entry by entry (registered memory read, then compare) until its label
// hits or the used entries run out, then bumps that count, inserts a new
// entry or flags overflow if the table is full; a word with no_neighbors
// set skips the scan. A word with is_last then loads the result register,
// waiting while it is still full; the result may wait there while the next
// word is already taken. The result register frees as out_ready is seen.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module label_propagation_vertex_update #(
    parameter int unsigned MAX_DISTINCT = lpvu_pkg::MAX_DISTINCT_DEF,
    parameter int unsigned LABEL_BITS   = lpvu_pkg::LABEL_BITS_DEF,
    parameter int unsigned COUNT_BITS   = lpvu_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [lpvu_pkg::PORT_LABEL_BITS-1:0]  neighbor_label,
    input  wire logic [lpvu_pkg::PORT_LABEL_BITS-1:0]  own_label,
    input  wire logic [lpvu_pkg::PORT_LABEL_BITS-1:0]  prev_label,
    input  wire logic                                  is_first,
    input  wire logic                                  is_last,
    input  wire logic                                  no_neighbors,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [lpvu_pkg::PORT_LABEL_BITS-1:0]       new_label,
    output logic                                       converged,
    output logic                                       table_overflow
);
    import lpvu_pkg::*;

    cmd_t    cmd;
    status_t sts;

    lpvu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lpvu_dpath #(
        .MAX_DISTINCT (MAX_DISTINCT),
        .LABEL_BITS   (LABEL_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .neighbor_label (neighbor_label),
        .own_label      (own_label),
        .prev_label     (prev_label),
        .is_first       (is_first),
        .is_last        (is_last),
        .no_neighbors   (no_neighbors),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .new_label      (new_label),
        .converged      (converged),
        .table_overflow (table_overflow)
    );

endmodule

`default_nettype wire

// File: src/lpvu_ctrl.sv
// ----------------------------------------------------------------------------
// lpvu_ctrl
// Sequencer for one neighbor word: table scan, hit, insert or overflow, result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpvu_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire lpvu_pkg::status_t sts,
    output lpvu_pkg::cmd_t       cmd
);
    import lpvu_pkg::*;

    `include "assert_macros.svh"

    state_t state_reg;
    state_t state_next;
    state_t done_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        done_state = sts.last ? S_FINISH : S_IDLE;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.in_none)
                    begin
                        state_next = sts.in_last ? S_FINISH : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                if (sts.idx_at_end)
                begin
                    if (sts.full)
                    begin
                        cmd.set_ovf = 1'b1;
                    end
                    else
                    begin
                        cmd.insert = 1'b1;
                    end
                    state_next = done_state;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (sts.hit)
                begin
                    cmd.bump   = 1'b1;
                    state_next = done_state;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `ASSERT_IMPLIES(a_insert_room, clk, rst_n, cmd.insert, !sts.full)
    `ASSERT_NEXT(a_load_to_scan, clk, rst_n, cmd.load && !sts.in_none, state_reg == S_READ)

endmodule

`default_nettype wire

// File: src/lpvu_dpath.sv
// ----------------------------------------------------------------------------
// lpvu_dpath
// Label and count memories, running best label and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpvu_dpath #(
    parameter int unsigned MAX_DISTINCT = lpvu_pkg::MAX_DISTINCT_DEF,
    parameter int unsigned LABEL_BITS   = lpvu_pkg::LABEL_BITS_DEF,
    parameter int unsigned COUNT_BITS   = lpvu_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire lpvu_pkg::cmd_t                        cmd,
    output lpvu_pkg::status_t                          sts,
    input  wire logic [lpvu_pkg::PORT_LABEL_BITS-1:0]  neighbor_label,
    input  wire logic [lpvu_pkg::PORT_LABEL_BITS-1:0]  own_label,
    input  wire logic [lpvu_pkg::PORT_LABEL_BITS-1:0]  prev_label,
    input  wire logic                                  is_first,
    input  wire logic                                  is_last,
    input  wire logic                                  no_neighbors,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [lpvu_pkg::PORT_LABEL_BITS-1:0]       new_label,
    output logic                                       converged,
    output logic                                       table_overflow
);
    import lpvu_pkg::*;

    `include "assert_macros.svh"

    localparam int unsigned UW = $clog2(MAX_DISTINCT + 1);
    localparam int unsigned AW = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1;

    logic [LABEL_BITS-1:0] label_mem [MAX_DISTINCT];
    logic [COUNT_BITS-1:0] count_mem [MAX_DISTINCT];

    logic [LABEL_BITS-1:0]      nbr_reg;
    logic [LABEL_BITS-1:0]      prev_reg;
    logic                       last_reg;
    logic [UW-1:0]              used_reg;
    logic [UW-1:0]              idx_reg;
    logic [COUNT_BITS-1:0]      best_count_reg;
    logic [LABEL_BITS-1:0]      best_label_reg;
    logic                       ovf_reg;
    logic [LABEL_BITS-1:0]      rd_label_reg;
    logic [COUNT_BITS-1:0]      rd_count_reg;
    logic                       out_valid_reg;
    logic [PORT_LABEL_BITS-1:0] out_label_reg;
    logic                       out_conv_reg;
    logic                       out_ovf_reg;

    logic [COUNT_BITS-1:0]      sat_count;
    logic [COUNT_BITS-1:0]      cand_count;
    logic                       best_upd;

    assign sat_count  = (rd_count_reg == '1) ? rd_count_reg
                                             : rd_count_reg + COUNT_BITS'(1);
    assign cand_count = cmd.insert ? COUNT_BITS'(1) : sat_count;
    assign best_upd   = (cmd.insert || cmd.bump)
                        && ((best_count_reg < cand_count)
                            || ((best_count_reg == cand_count)
                                && (nbr_reg > best_label_reg)));

    always_comb
    begin
        sts.in_none    = no_neighbors;
        sts.in_last    = is_last;
        sts.last       = last_reg;
        sts.idx_at_end = (idx_reg == used_reg);
        sts.hit        = (rd_label_reg == nbr_reg);
        sts.full       = (used_reg == UW'(MAX_DISTINCT));
        sts.out_free   = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg       <= 1'b0;
            used_reg       <= '0;
            idx_reg        <= '0;
            best_count_reg <= '0;
            best_label_reg <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                last_reg <= is_last;
                idx_reg  <= '0;
                if (is_first)
                begin
                    used_reg       <= '0;
                    best_count_reg <= '0;
                    best_label_reg <= LABEL_BITS'(own_label);
                    ovf_reg        <= 1'b0;
                end
            end
            if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + UW'(1);
            end
            if (cmd.insert)
            begin
                used_reg <= used_reg + UW'(1);
            end
            if (cmd.set_ovf)
            begin
                ovf_reg <= 1'b1;
            end
            if (best_upd)
            begin
                best_count_reg <= cand_count;
                best_label_reg <= nbr_reg;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            nbr_reg  <= LABEL_BITS'(neighbor_label);
            prev_reg <= LABEL_BITS'(prev_label);
        end
        if (cmd.out_load)
        begin
            out_label_reg <= PORT_LABEL_BITS'(best_label_reg);
            out_conv_reg  <= (best_label_reg == prev_reg);
            out_ovf_reg   <= ovf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            label_mem[used_reg[AW-1:0]] <= nbr_reg;
            count_mem[used_reg[AW-1:0]] <= COUNT_BITS'(1);
        end
        else if (cmd.bump)
        begin
            count_mem[idx_reg[AW-1:0]] <= sat_count;
        end
        if (cmd.rd_en)
        begin
            rd_label_reg <= label_mem[idx_reg[AW-1:0]];
            rd_count_reg <= count_mem[idx_reg[AW-1:0]];
        end
    end

    assign out_valid      = out_valid_reg;
    assign new_label      = out_label_reg;
    assign converged      = out_conv_reg;
    assign table_overflow = out_ovf_reg;

    `ASSERT_ALWAYS(a_scan_in_table, clk, rst_n, idx_reg <= used_reg)
    `ASSERT_NEXT(a_insert_best, clk, rst_n, cmd.insert, best_count_reg != '0)

endmodule

`default_nettype wire

// File: tb/tb_label_propagation_vertex_update.sv
// ----------------------------------------------------------------------------
// tb_label_propagation_vertex_update
// Self-checking bench for the vertex label update block.
// ----------------------------------------------------------------------------
// A table of directed words runs first. It covers reset state, the label
// extremes, vertices with no neighbors, ties, runs without a first word, a
// full count table and a frequent label against a larger rare one. Random
// vertices follow, some of them well-formed, some broken and some pure noise.
// Every accepted word goes through a local model of the count table. Each
// result is checked field by field against the oldest predicted one. Both
// sides idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_label_propagation_vertex_update;

    import lpvu_pkg::*;

    localparam int unsigned LW           = PORT_LABEL_BITS;
    localparam int unsigned DEPTH        = MAX_DISTINCT_DEF;
    localparam int unsigned CNT_SAT      = (1 << COUNT_BITS_DEF) - 1;
    localparam int unsigned RANDOM_WORDS = 1360;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 20;
    localparam int unsigned LIMIT_CYCLES = 2_000_000;

    typedef struct packed {
        logic [LW-1:0] nbr;
        logic [LW-1:0] own;
        logic [LW-1:0] prev;
        logic          first;
        logic          last;
        logic          none;
    } word_t;

    typedef struct packed {
        logic [LW-1:0] label;
        logic          conv;
        logic          ovf;
    } result_t;

    typedef struct packed {
        word_t         w;
        logic [31:0]   reps;
        logic [LW-1:0] step;
        logic          typed;
        result_t       want;
    } stim_row_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic [LW-1:0] neighbor_label;
    logic [LW-1:0] own_label;
    logic [LW-1:0] prev_label;
    logic          is_first;
    logic          is_last;
    logic          no_neighbors;
    logic          out_valid;
    logic          out_ready;
    logic [LW-1:0] new_label;
    logic          converged;
    logic          table_overflow;

    label_propagation_vertex_update u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .neighbor_label (neighbor_label),
        .own_label      (own_label),
        .prev_label     (prev_label),
        .is_first       (is_first),
        .is_last        (is_last),
        .no_neighbors   (no_neighbors),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .new_label      (new_label),
        .converged      (converged),
        .table_overflow (table_overflow)
    );

    // local copy of the count table
    logic [LW-1:0] lbl_mem [DEPTH];
    int unsigned   cnt_mem [DEPTH];
    int unsigned   n_used;
    int unsigned   top_cnt;
    logic [LW-1:0] top_lbl;
    bit            ovf_seen;

    result_t       pending_labels [$];
    stim_row_t     dir_rows [$];
    result_t       head;
    int unsigned   mismatches;
    int unsigned   words_sent;
    int unsigned   cycles;
    bit            long_hold_req;
    int unsigned   run_left;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("[label_propagation_vertex_update] ERROR");
            $finish;
        end
    end

    function automatic void tally_label(input logic [LW-1:0] lbl);
        int unsigned idx;
        int unsigned c;
        bit          found;
        found = 1'b0;
        idx   = n_used;
        for (int unsigned i = 0; i < n_used; i++)
        begin
            if (!found && lbl_mem[i] == lbl)
            begin
                idx   = i;
                found = 1'b1;
            end
        end
        if (!found)
        begin
            if (n_used >= DEPTH)
            begin
                ovf_seen = 1'b1;
                return;
            end
            lbl_mem[n_used] = lbl;
            cnt_mem[n_used] = 0;
            n_used++;
        end
        c = cnt_mem[idx];
        if (c < CNT_SAT)
            c++;
        cnt_mem[idx] = c;
        if (top_cnt < c || (top_cnt == c && lbl > top_lbl))
        begin
            top_cnt = c;
            top_lbl = lbl;
        end
    endfunction

    function automatic bit propagate_word(input word_t w, output result_t r);
        if (w.first)
        begin
            n_used   = 0;
            top_cnt  = 0;
            top_lbl  = w.own;
            ovf_seen = 1'b0;
        end
        if (!w.none)
            tally_label(w.nbr);
        r.label = top_lbl;
        r.conv  = (top_lbl == w.prev);
        r.ovf   = ovf_seen;
        return w.last;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [LW-1:0] pick_label();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom;
        if (r < 60)
            return $urandom_range(0, 15);
        if (r < 70)
            return {LW{1'b1}} - $urandom_range(0, 3);
        return $urandom_range(0, 255);
    endfunction

    task automatic send_word(input word_t w, input bit gapless, input bit typed,
                             input result_t want);
        int unsigned n;
        result_t     r;
        @(negedge clk);
        n = gapless ? 0 : pick_gap();
        repeat (n)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        neighbor_label = w.nbr;
        own_label      = w.own;
        prev_label     = w.prev;
        is_first       = w.first;
        is_last        = w.last;
        no_neighbors   = w.none;
        in_valid       = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (propagate_word(w, r))
            pending_labels.push_back(typed ? want : r);
        words_sent++;
    endtask

    task automatic add_row(input logic [LW-1:0] nbr, input logic [LW-1:0] own,
                           input logic [LW-1:0] prev, input bit first, input bit last,
                           input bit none, input int unsigned reps,
                           input logic [LW-1:0] step, input bit typed,
                           input logic [LW-1:0] want_label, input bit want_conv,
                           input bit want_ovf);
        stim_row_t row;
        row.w     = '{nbr: nbr, own: own, prev: prev, first: first, last: last,
                      none: none};
        row.reps  = reps;
        row.step  = step;
        row.typed = typed;
        row.want  = '{label: want_label, conv: want_conv, ovf: want_ovf};
        dir_rows.push_back(row);
    endtask

    // result side: random stalls plus one long hold on request
    initial
    begin
        int unsigned r;
        out_ready = 1'b0;
        run_left  = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ready     = 1'b0;
                run_left      = HOLD_CYCLES;
            end
            else if (run_left == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    out_ready = 1'b1;
                    run_left  = $urandom_range(1, 20);
                end
                else if (r < 85)
                begin
                    out_ready = 1'b0;
                    run_left  = $urandom_range(1, 3);
                end
                else if (r < 95)
                begin
                    out_ready = 1'b1;
                    run_left  = $urandom_range(50, 200);
                end
                else
                begin
                    out_ready = 1'b0;
                    run_left  = $urandom_range(10, 40);
                end
            end
            else
                run_left--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_labels.size() == 0)
            begin
                $display("%0t: unexpected word, new_label %h", $time, new_label);
                mismatches++;
            end
            else
            begin
                head = pending_labels.pop_front();
                if (new_label !== head.label)
                begin
                    $display("%0t: new_label expected %h actual %h", $time,
                             head.label, new_label);
                    mismatches++;
                end
                if (converged !== head.conv)
                begin
                    $display("%0t: converged expected %0b actual %0b", $time,
                             head.conv, converged);
                    mismatches++;
                end
                if (table_overflow !== head.ovf)
                begin
                    $display("%0t: table_overflow expected %0b actual %0b", $time,
                             head.ovf, table_overflow);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t     row;
        word_t         w;
        logic [LW-1:0] pool [8];
        logic [LW-1:0] base;
        int unsigned   kind;
        int unsigned   len;
        int unsigned   psize;
        int unsigned   r;
        bit            calm;

        in_valid       = 1'b0;
        neighbor_label = '0;
        own_label      = '0;
        prev_label     = '0;
        is_first       = 1'b0;
        is_last        = 1'b0;
        no_neighbors   = 1'b0;
        rst_n          = 1'b0;
        words_sent     = 0;
        long_hold_req  = 1'b0;
        n_used         = 0;
        top_cnt        = 0;
        top_lbl        = '0;
        ovf_seen       = 1'b0;

        //       nbr           own           prev          f  l  n  reps   step
        add_row(32'd5,        32'd0,        32'd5,        0, 1, 0, 1,     0,
                1, 32'd5, 1, 0);
        add_row(32'd12345,    32'hFFFFFFFF, 32'hFFFFFFFF, 1, 1, 1, 1,     0,
                1, 32'hFFFFFFFF, 1, 0);
        add_row(32'hFFFFFFFF, 32'd0,        32'd1,        1, 1, 1, 1,     0,
                1, 32'd0, 0, 0);
        add_row(32'd0,        32'hFFFFFFFF, 32'd0,        1, 1, 0, 1,     0,
                1, 32'd0, 1, 0);
        add_row(32'hFFFFFFFF, 32'd0,        32'd0,        1, 0, 0, 1,     0,
                0, '0, 0, 0);
        add_row(32'd0,        32'd0,        32'd0,        0, 0, 0, 1,     0,
                0, '0, 0, 0);
        add_row(32'd0,        32'd0,        32'd0,        0, 1, 0, 1,     0,
                0, '0, 0, 0);
        add_row(32'd10,       32'd99,       32'd0,        1, 0, 0, 1,     0,
                0, '0, 0, 0);
        add_row(32'd20,       32'd0,        32'd0,        0, 0, 0, 1,     0,
                0, '0, 0, 0);
        add_row(32'd0,        32'd0,        32'd20,       0, 1, 1, 1,     0,
                0, '0, 0, 0);
        add_row(32'd20,       32'd0,        32'd7,        0, 1, 0, 1,     0,
                0, '0, 0, 0);
        // fill the table, overflow it, then hit its last entry
        add_row(32'd1000,     32'd7,        32'd0,        1, 0, 0, 1,     0,
                0, '0, 0, 0);
        add_row(32'd1001,     32'd0,        32'd0,        0, 0, 0, DEPTH - 1, 1,
                0, '0, 0, 0);
        add_row(32'd5000,     32'd0,        32'd0,        0, 0, 0, 1,     0,
                0, '0, 0, 0);
        add_row(32'd1063,     32'd0,        32'd0,        0, 0, 0, 2,     0,
                0, '0, 0, 0);
        add_row(32'd1000,     32'd0,        32'd1063,     0, 1, 0, 1,     0,
                0, '0, 0, 0);
        add_row(32'd3,        32'd0,        32'd3,        1, 1, 0, 1,     0,
                1, 32'd3, 1, 0);
        // repeat one label, then a larger but rarer label must not overtake it
        add_row(32'd77,       32'd0,        32'd0,        1, 0, 0, 6,     0,
                0, '0, 0, 0);
        add_row(32'd900,      32'd0,        32'd0,        0, 0, 0, 3,     0,
                0, '0, 0, 0);
        add_row(32'd77,       32'd0,        32'd77,       0, 1, 0, 1,     0,
                0, '0, 0, 0);
        add_row(32'd9,        32'd0,        32'd0,        1, 0, 0, 1,     0,
                0, '0, 0, 0);
        add_row(32'd500,      32'd0,        32'd0,        0, 0, 1, 1,     0,
                0, '0, 0, 0);
        add_row(32'd8,        32'd0,        32'd8,        0, 1, 0, 1,     0,
                0, '0, 0, 0);

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            for (int unsigned k = 0; k < row.reps; k++)
            begin
                w       = row.w;
                w.nbr   = row.w.nbr + k * row.step;
                w.first = row.w.first && (k == 0);
                w.last  = row.w.last && (k == row.reps - 1);
                send_word(w, row.reps > 100, row.typed && (k == row.reps - 1),
                          row.want);
            end
        end

        long_hold_req = 1'b1;
        words_sent    = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            kind  = $urandom_range(0, 99);
            calm  = ($urandom_range(0, 4) == 0);
            psize = $urandom_range(1, 6);
            for (int unsigned i = 0; i < 8; i++)
                pool[i] = pick_label();
            if (kind < 6)
            begin
                w = '{nbr: $urandom, own: pick_label(), prev: pick_label(),
                      first: 1'b1, last: 1'b1, none: 1'b1};
                if ($urandom_range(0, 1) == 1)
                    w.prev = w.own;
                send_word(w, calm, 1'b0, '0);
            end
            else if (kind < 14)
            begin
                len = $urandom_range(1, 6);
                for (int unsigned i = 0; i < len; i++)
                begin
                    w = '{nbr: pool[$urandom_range(0, psize - 1)], own: pick_label(),
                          prev: pick_label(), first: 1'($urandom_range(0, 1)),
                          last: 1'($urandom_range(0, 1)),
                          none: ($urandom_range(0, 3) == 0)};
                    send_word(w, calm, 1'b0, '0);
                end
            end
            else if (kind < 17)
            begin
                len  = $urandom_range(DEPTH - 4, DEPTH + 6);
                base = $urandom;
                for (int unsigned i = 0; i < len; i++)
                begin
                    r = (i > 0 && $urandom_range(0, 4) == 0) ? $urandom_range(0, i - 1) : i;
                    w = '{nbr: base + r, own: pick_label(),
                          prev: base + $urandom_range(0, 3), first: (i == 0),
                          last: (i == len - 1), none: 1'b0};
                    send_word(w, calm, 1'b0, '0);
                end
            end
            else
            begin
                len = $urandom_range(1, 14);
                for (int unsigned i = 0; i < len; i++)
                begin
                    w = '{nbr: pool[$urandom_range(0, psize - 1)], own: pick_label(),
                          prev: pick_label(), first: (i == 0), last: (i == len - 1),
                          none: ($urandom_range(0, 19) == 0)};
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        w.prev = pool[$urandom_range(0, psize - 1)];
                    else if (r < 55)
                        w.prev = w.own;
                    send_word(w, calm, 1'b0, '0);
                end
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (pending_labels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[label_propagation_vertex_update] OK");
        else
            $display("[label_propagation_vertex_update] ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/lpvu_pkg.sv
src/lpvu_ctrl.sv
src/lpvu_dpath.sv
src/label_propagation_vertex_update.sv
tb/tb_label_propagation_vertex_update.sv
